FILE: rtl/core/sue_pkg.sv
// Shared types and constants for the SuperEagle 2x upscale block.
package sue_pkg;

    // Significant low bits of each packed pixel; the rest are ignored on input and zero on output.
    localparam int PIXEL_BITS = 32;
    localparam int WORD_BITS  = 32;

    localparam logic [WORD_BITS-1:0] PIX_MASK =
        WORD_BITS'((64'd1 << PIXEL_BITS) - 64'd1);

    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_MASK        = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_LOW_MASK    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUARTER_MASK     = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_QUARTER_LOW_MASK = 2'd3;

    localparam logic [WORD_BITS-1:0] HALF_MASK_RST        = 32'hF7DE_F7DE;
    localparam logic [WORD_BITS-1:0] HALF_LOW_MASK_RST    = 32'h0821_0821;
    localparam logic [WORD_BITS-1:0] QUARTER_MASK_RST     = 32'hE79C_E79C;
    localparam logic [WORD_BITS-1:0] QUARTER_LOW_MASK_RST = 32'h1863_1863;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        word_t above_mid;
        word_t above_right;
        word_t left_px;
        word_t center_px;
        word_t right_px;
        word_t right_far;
        word_t below_left;
        word_t below_mid;
        word_t below_right;
        word_t below_right_far;
        word_t two_below_mid;
        word_t two_below_right;
    } sue_in_t;

    typedef struct packed {
        word_t out_top_left;
        word_t out_top_right;
        word_t out_bottom_left;
        word_t out_bottom_right;
    } sue_out_t;

endpackage

FILE: rtl/core/supereagle_upscale_block.sv
// SuperEagle 2x upscaler: neighborhood in, 2x2 output block out, three register stages.
//
// One source pixel neighborhood is taken per clock while s_ready is high; its 2x2 block passes
// through the stages in order: stage one registers the diagonal tests, the vote and the first
// averages, stage two the nested and four-pixel averages, stage three the selected block, which
// is the output register. Every stage holds while the stage after it is full and stalled, so a
// stall on the output side backs up into s_ready only once all three stages are occupied. The
// user must write the four averaging masks through the cfg port only while no item is in flight;
// the block itself does not enforce this. A write takes effect at once.
module supereagle_upscale_block (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sue_pkg::sue_in_t                   s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sue_pkg::sue_out_t                  m_data,
    input  logic                               cfg_wr_en,
    input  logic [sue_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sue_pkg::WORD_BITS-1:0]      cfg_wdata
);
    import sue_pkg::*;

    localparam logic [1:0] KIND_EDGE_DN_RT = 2'd0;  // dn/rt diagonal alone matches
    localparam logic [1:0] KIND_EDGE_C_DR  = 2'd1;  // c/dr diagonal alone matches
    localparam logic [1:0] KIND_BOTH       = 2'd2;
    localparam logic [1:0] KIND_NONE       = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic       c1_tl;
        logic       c1_br;
        logic       c2_tr;
        logic       c2_bl;
        logic       vpos;
        logic       vneg;
    } sel_t;

    typedef struct packed {
        sel_t  sel;
        word_t c;
        word_t rt;
        word_t dn;
        word_t dr;
        word_t a_dnc;
        word_t a_dndr;
        word_t a_crt;
        word_t a_cdn;
        word_t d1;
        word_t d2;
    } st1_t;

    typedef struct packed {
        sel_t  sel;
        word_t c;
        word_t dn;
        word_t a_crt;
        word_t a_dndr;
        word_t s_dnc;
        word_t s_dndr;
        word_t s_crt;
        word_t s_cdn;
        word_t q_tl;
        word_t q_tr;
        word_t q_bl;
        word_t q_br;
    } st2_t;

    word_t half_mask_reg, half_low_mask_reg, quarter_mask_reg, quarter_low_mask_reg;

    logic     v1_reg, v2_reg, v3_reg;
    st1_t     st1_reg, st1_next;
    st2_t     st2_reg, st2_next;
    sue_out_t st3_reg, st3_next;
    logic     rdy1, rdy2, rdy3;

    function automatic word_t avg2(word_t a, word_t b, word_t hm, word_t hlm);
        return ((a & hm) >> 1) + ((b & hm) >> 1) + (a & b & hlm);
    endfunction

    function automatic word_t avg4(word_t a, word_t b, word_t c, word_t d,
                                   word_t qm, word_t qlm);
        word_t hi;
        word_t lo;
        hi = ((a & qm) >> 2) + ((b & qm) >> 2) + ((c & qm) >> 2) + ((d & qm) >> 2);
        lo = (a & qlm) + (b & qlm) + (c & qlm) + (d & qlm);
        return hi + ((lo >> 2) & qlm);
    endfunction

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_mask_reg        <= HALF_MASK_RST;
            half_low_mask_reg    <= HALF_LOW_MASK_RST;
            quarter_mask_reg     <= QUARTER_MASK_RST;
            quarter_low_mask_reg <= QUARTER_LOW_MASK_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_HALF_MASK:        half_mask_reg        <= cfg_wdata;
                REG_HALF_LOW_MASK:    half_low_mask_reg    <= cfg_wdata;
                REG_QUARTER_MASK:     quarter_mask_reg     <= cfg_wdata;
                REG_QUARTER_LOW_MASK: quarter_low_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage takes new data when it is empty or its content moves on.
    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    // Stage one: diagonal tests, vote and first-level averages
    always_comb begin
        word_t up, upr, lf, c, rt, rf, dl, dn, dr, drf, dd, ddr;
        logic [3:0] pa, pb;
        logic [2:0] cnt_a, cnt_b;
        up  = s_data.above_mid       & PIX_MASK;
        upr = s_data.above_right     & PIX_MASK;
        lf  = s_data.left_px         & PIX_MASK;
        c   = s_data.center_px       & PIX_MASK;
        rt  = s_data.right_px        & PIX_MASK;
        rf  = s_data.right_far       & PIX_MASK;
        dl  = s_data.below_left      & PIX_MASK;
        dn  = s_data.below_mid       & PIX_MASK;
        dr  = s_data.below_right     & PIX_MASK;
        drf = s_data.below_right_far & PIX_MASK;
        dd  = s_data.two_below_mid   & PIX_MASK;
        ddr = s_data.two_below_right & PIX_MASK;

        if (dn == rt && c != dr) begin
            st1_next.sel.kind = KIND_EDGE_DN_RT;
        end else if (c == dr && dn != rt) begin
            st1_next.sel.kind = KIND_EDGE_C_DR;
        end else if (c == dr) begin
            st1_next.sel.kind = KIND_BOTH;
        end else begin
            st1_next.sel.kind = KIND_NONE;
        end
        st1_next.sel.c1_tl = (dl == dn) || (rt == upr);
        st1_next.sel.c1_br = (rt == rf) || (dn == dd);
        st1_next.sel.c2_tr = (up == c) || (dr == drf);
        st1_next.sel.c2_bl = (dr == ddr) || (lf == c);

        // Vote sum sign: count right-pixel terms against center terms
        pa[0] = (rt != dl)  || (rt != dd);
        pa[1] = (rt != lf)  || (rt != up);
        pa[2] = (rt != ddr) || (rt != drf);
        pa[3] = (rt != upr) || (rt != rf);
        pb[0] = (c != dl)   || (c != dd);
        pb[1] = (c != lf)   || (c != up);
        pb[2] = (c != ddr)  || (c != drf);
        pb[3] = (c != upr)  || (c != rf);
        cnt_a = 3'(pa[0]) + 3'(pa[1]) + 3'(pa[2]) + 3'(pa[3]);
        cnt_b = 3'(pb[0]) + 3'(pb[1]) + 3'(pb[2]) + 3'(pb[3]);
        st1_next.sel.vpos = cnt_a > cnt_b;
        st1_next.sel.vneg = cnt_a < cnt_b;

        st1_next.c      = c;
        st1_next.rt     = rt;
        st1_next.dn     = dn;
        st1_next.dr     = dr;
        st1_next.a_dnc  = avg2(dn, c,  half_mask_reg, half_low_mask_reg);
        st1_next.a_dndr = avg2(dn, dr, half_mask_reg, half_low_mask_reg);
        st1_next.a_crt  = avg2(c,  rt, half_mask_reg, half_low_mask_reg);
        st1_next.a_cdn  = avg2(c,  dn, half_mask_reg, half_low_mask_reg);
        st1_next.d1     = avg2(dn, rt, half_mask_reg, half_low_mask_reg);
        st1_next.d2     = avg2(c,  dr, half_mask_reg, half_low_mask_reg);
    end

    // Stage two: nested and four-pixel averages
    always_comb begin
        st2_next.sel    = st1_reg.sel;
        st2_next.c      = st1_reg.c;
        st2_next.dn     = st1_reg.dn;
        st2_next.a_crt  = st1_reg.a_crt;
        st2_next.a_dndr = st1_reg.a_dndr;
        st2_next.s_dnc  = avg2(st1_reg.dn, st1_reg.a_dnc, half_mask_reg, half_low_mask_reg);
        st2_next.s_dndr = avg2(st1_reg.dn, st1_reg.a_dndr, half_mask_reg, half_low_mask_reg);
        st2_next.s_crt  = avg2(st1_reg.c, st1_reg.a_crt, half_mask_reg, half_low_mask_reg);
        st2_next.s_cdn  = avg2(st1_reg.c, st1_reg.a_cdn, half_mask_reg, half_low_mask_reg);
        st2_next.q_tl   = avg4(st1_reg.c, st1_reg.c, st1_reg.c, st1_reg.d1,
                               quarter_mask_reg, quarter_low_mask_reg);
        st2_next.q_br   = avg4(st1_reg.dr, st1_reg.dr, st1_reg.dr, st1_reg.d1,
                               quarter_mask_reg, quarter_low_mask_reg);
        st2_next.q_bl   = avg4(st1_reg.dn, st1_reg.dn, st1_reg.dn, st1_reg.d2,
                               quarter_mask_reg, quarter_low_mask_reg);
        st2_next.q_tr   = avg4(st1_reg.rt, st1_reg.rt, st1_reg.rt, st1_reg.d2,
                               quarter_mask_reg, quarter_low_mask_reg);
    end

    // Stage three: pick the block by case
    always_comb begin
        word_t tl, tr, bl, br;
        case (st2_reg.sel.kind)
            KIND_EDGE_DN_RT: begin
                tr = st2_reg.dn;
                bl = st2_reg.dn;
                tl = st2_reg.sel.c1_tl ? st2_reg.s_dnc : st2_reg.a_crt;
                br = st2_reg.sel.c1_br ? st2_reg.s_dndr : st2_reg.a_dndr;
            end
            KIND_EDGE_C_DR: begin
                tl = st2_reg.c;
                br = st2_reg.c;
                tr = st2_reg.sel.c2_tr ? st2_reg.s_crt : st2_reg.a_crt;
                bl = st2_reg.sel.c2_bl ? st2_reg.s_cdn : st2_reg.a_dndr;
            end
            KIND_BOTH: begin
                if (st2_reg.sel.vpos) begin
                    tr = st2_reg.dn;
                    bl = st2_reg.dn;
                    tl = st2_reg.a_crt;
                    br = st2_reg.a_crt;
                end else if (st2_reg.sel.vneg) begin
                    tl = st2_reg.c;
                    br = st2_reg.c;
                    bl = st2_reg.a_crt;
                    tr = st2_reg.a_crt;
                end else begin
                    tl = st2_reg.c;
                    br = st2_reg.c;
                    bl = st2_reg.dn;
                    tr = st2_reg.dn;
                end
            end
            default: begin
                tl = st2_reg.q_tl;
                tr = st2_reg.q_tr;
                bl = st2_reg.q_bl;
                br = st2_reg.q_br;
            end
        endcase
        st3_next.out_top_left     = tl & PIX_MASK;
        st3_next.out_top_right    = tr & PIX_MASK;
        st3_next.out_bottom_left  = bl & PIX_MASK;
        st3_next.out_bottom_right = br & PIX_MASK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Payload advances with its stage; hold otherwise.
    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            st1_reg <= st1_next;
        end
        if (rdy2 && v1_reg) begin
            st2_reg <= st2_next;
        end
        if (rdy3 && v2_reg) begin
            st3_reg <= st3_next;
        end
    end

    assign m_valid = v3_reg;
    assign m_data  = st3_reg;

endmodule

FILE: rtl/core/sue_checker.sv
// Port-level checks for the SuperEagle upscale block, bound to the top level.
module sue_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sue_pkg::sue_out_t m_data
);
    import sue_pkg::*;

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("result changed or dropped while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // With the output side free the block never backs up.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output side is free");

    // An accepted transfer reaches the output when the output side does not stall it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready |=> m_valid)
        else $error("result missing after pipeline latency");

endmodule

bind supereagle_upscale_block sue_checker u_sue_checker (.*);
